[design/euler_trs_matrix_compose_unit_assert.svh]
// Assertion macros for the matrix compose unit
`ifndef EULER_TRS_MATRIX_COMPOSE_UNIT_ASSERT_SVH
`define EULER_TRS_MATRIX_COMPOSE_UNIT_ASSERT_SVH

// same-cycle implication
`define ETMC_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ETMC_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[design/etmc_pkg.sv]
// Types, constants and arithmetic helpers for the matrix compose unit
package etmc_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int LANE_LAT        = TRIG_ITERATIONS + 3;
   localparam int MERGE_LAT       = 4;
   localparam int TOTAL_LAT       = LANE_LAT + MERGE_LAT;

   typedef logic signed [33:0] q30_type;
   typedef logic signed [35:0] ang_type;
   typedef logic signed [31:0] elem_type;
   typedef logic signed [15:0] scl_type;
   typedef elem_type [2:0][2:0] mat_type;

   localparam ang_type  Q30_PI      = 36'sd3373259426;
   localparam ang_type  Q30_TWO_PI  = 36'sd6746518852;
   localparam ang_type  Q30_HALF_PI = 36'sd1686629713;
   localparam q30_type  CORDIC_K    = 34'sd652032874;
   localparam elem_type ONE_Q16     = 32'sd65536;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem0;
      logic signed [31:0] elem1;
      logic signed [31:0] elem2;
      logic signed [31:0] elem3;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      q30_type sx;
      q30_type cx;
      q30_type sy;
      q30_type cy;
      q30_type sz;
      q30_type cz;
   } trig_type;

   typedef struct packed {
      scl_type s0;
      scl_type s1;
      scl_type s2;
   } scale_type;

   function automatic ang_type atan_q30(input int idx);
      ang_type r;
      case (idx)
         0:  r = 36'sh03243F6A8;
         1:  r = 36'sh01DAC6705;
         2:  r = 36'sh00FADBAFC;
         3:  r = 36'sh007F56EA6;
         4:  r = 36'sh003FEAB76;
         5:  r = 36'sh001FFD55B;
         6:  r = 36'sh000FFFAAA;
         7:  r = 36'sh0007FFF55;
         8:  r = 36'sh0003FFFEA;
         9:  r = 36'sh0001FFFFD;
         10: r = 36'sh0000FFFFF;
         11: r = 36'sh00007FFFF;
         12: r = 36'sh00003FFFF;
         13: r = 36'sh00001FFFF;
         14: r = 36'sh00000FFFF;
         15: r = 36'sh000007FFF;
         16: r = 36'sh000003FFF;
         17: r = 36'sh000001FFF;
         18: r = 36'sh000000FFF;
         19: r = 36'sh0000007FF;
         20: r = 36'sh0000003FF;
         21: r = 36'sh0000001FF;
         22: r = 36'sh0000000FF;
         23: r = 36'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 x Q30, round half up
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return q30_type'(p >>> 30);
   endfunction

   // Q30 element x Q8.8 scale -> saturated Q16.16
   function automatic elem_type scaled(input q30_type e, input scl_type s);
      logic signed [49:0] p;
      logic signed [49:0] v;
      elem_type r;
      p = 50'(e) * 50'(s) + 50'sd2097152;
      v = p >>> 22;
      if (v > 50'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = elem_type'(v);
      end
      return r;
   endfunction

endpackage

[design/etmc_cordic_lane.sv]
// One sine/cosine lane: range reduction, quadrant fold and pipelined CORDIC
module etmc_cordic_lane (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] angle,
   output etmc_pkg::q30_type  sin_out,
   output etmc_pkg::q30_type  cos_out
);
   import etmc_pkg::*;

   ang_type z0;
   ang_type zr_in;
   ang_type zr_ff;
   ang_type zf_in;
   logic    neg_in;

   q30_type x_ff   [0:TRIG_ITERATIONS];
   q30_type y_ff   [0:TRIG_ITERATIONS];
   ang_type z_ff   [0:TRIG_ITERATIONS];
   logic    neg_ff [0:TRIG_ITERATIONS];
   q30_type sin_ff;
   q30_type cos_ff;

   assign z0 = {{2{angle[15]}}, angle, 18'b0};

   always_comb begin
      if (z0 > Q30_PI) begin
         zr_in = z0 - Q30_TWO_PI;
      end else if (z0 < -Q30_PI) begin
         zr_in = z0 + Q30_TWO_PI;
      end else begin
         zr_in = z0;
      end
   end

   always_comb begin
      neg_in = 1'b0;
      zf_in  = zr_ff;
      if (zr_ff > Q30_HALF_PI) begin
         zf_in  = zr_ff - Q30_PI;
         neg_in = 1'b1;
      end else if (zr_ff < -Q30_HALF_PI) begin
         zf_in  = zr_ff + Q30_PI;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zr_ff     <= zr_in;
         x_ff[0]   <= CORDIC_K;
         y_ff[0]   <= '0;
         z_ff[0]   <= zf_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= neg_ff[TRIG_ITERATIONS] ? -y_ff[TRIG_ITERATIONS] : y_ff[TRIG_ITERATIONS];
         cos_ff <= neg_ff[TRIG_ITERATIONS] ? -x_ff[TRIG_ITERATIONS] : x_ff[TRIG_ITERATIONS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

[design/etmc_merge.sv]
// Merge stage: combines lane sines/cosines into the scaled 3x3 rotation
module etmc_merge (
   input  logic                clock,
   input  logic                en,
   input  etmc_pkg::trig_type  trig,
   input  etmc_pkg::scale_type scale,
   output etmc_pkg::mat_type   mat
);
   import etmc_pkg::*;

   q30_type sxsy_ff, cxsy_ff, r00_ff, r01_ff, r02_ff, r12_ff, r22_ff;
   q30_type cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff, sz_ff, cz_ff;
   q30_type t1_ff, t2_ff, t3_ff, t4_ff;
   q30_type a00_ff, a01_ff, a02_ff, a12_ff, a22_ff;
   q30_type b00_ff, b01_ff, b02_ff, b12_ff, b22_ff;
   q30_type c_cxsz_ff, c_cxcz_ff, c_sxsz_ff, c_sxcz_ff;
   q30_type b10_ff, b11_ff, b20_ff, b21_ff;
   scale_type s1_ff, s2_ff, s3_ff;
   mat_type mat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sxsy_ff <= mul30(trig.sx, trig.sy);
         cxsy_ff <= mul30(trig.cx, trig.sy);
         r00_ff  <= mul30(trig.cy, trig.cz);
         r01_ff  <= mul30(trig.cy, trig.sz);
         r02_ff  <= -trig.sy;
         r12_ff  <= -mul30(trig.sx, trig.cy);
         r22_ff  <= mul30(trig.cx, trig.cy);
         cxsz_ff <= mul30(trig.cx, trig.sz);
         cxcz_ff <= mul30(trig.cx, trig.cz);
         sxsz_ff <= mul30(trig.sx, trig.sz);
         sxcz_ff <= mul30(trig.sx, trig.cz);
         sz_ff   <= trig.sz;
         cz_ff   <= trig.cz;
         s1_ff   <= scale;

         t1_ff     <= mul30(sxsy_ff, cz_ff);
         t2_ff     <= mul30(sxsy_ff, sz_ff);
         t3_ff     <= mul30(cxsy_ff, cz_ff);
         t4_ff     <= mul30(cxsy_ff, sz_ff);
         a00_ff    <= r00_ff;
         a01_ff    <= r01_ff;
         a02_ff    <= r02_ff;
         a12_ff    <= r12_ff;
         a22_ff    <= r22_ff;
         c_cxsz_ff <= cxsz_ff;
         c_cxcz_ff <= cxcz_ff;
         c_sxsz_ff <= sxsz_ff;
         c_sxcz_ff <= sxcz_ff;
         s2_ff     <= s1_ff;

         b10_ff <= -t1_ff - c_cxsz_ff;
         b11_ff <= -t2_ff + c_cxcz_ff;
         b20_ff <= t3_ff - c_sxsz_ff;
         b21_ff <= t4_ff + c_sxcz_ff;
         b00_ff <= a00_ff;
         b01_ff <= a01_ff;
         b02_ff <= a02_ff;
         b12_ff <= a12_ff;
         b22_ff <= a22_ff;
         s3_ff  <= s2_ff;

         mat_ff[0][0] <= scaled(b00_ff, s3_ff.s0);
         mat_ff[0][1] <= scaled(b01_ff, s3_ff.s1);
         mat_ff[0][2] <= scaled(b02_ff, s3_ff.s2);
         mat_ff[1][0] <= scaled(b10_ff, s3_ff.s0);
         mat_ff[1][1] <= scaled(b11_ff, s3_ff.s1);
         mat_ff[1][2] <= scaled(b12_ff, s3_ff.s2);
         mat_ff[2][0] <= scaled(b20_ff, s3_ff.s0);
         mat_ff[2][1] <= scaled(b21_ff, s3_ff.s1);
         mat_ff[2][2] <= scaled(b22_ff, s3_ff.s2);
      end
   end

   assign mat = mat_ff;

endmodule

[design/euler_trs_matrix_compose_unit.sv]
// Top level: Euler-angle translate/rotate/scale 4x4 matrix composer
//
// Input channel req_valid/req_ready/req_payload carries one transaction per
// transform: translation (Q16.16), Euler angles (Q4.12 rad), scales (Q8.8).
// Result channel rsp_valid/rsp_ready/rsp_payload returns four transactions
// per input, rows 0..3 of the row-major matrix; last_row marks row 3.
// Sustained input is limited by the single result channel, which drains
// four rows per transform. Three CORDIC lanes (one per angle) run one
// pipelined step per stage, and a merge pipeline forms the rotation
// products and scaling; the input is taken every cycle until the pipeline
// backs up behind the row sequencer.
// Reset clears all valid state; no result is pending after reset.
// When rsp_ready is low, the current row holds and the whole pipeline
// freezes once its last stage holds a finished transform; req_ready then
// drops until the row sequencer can take that transform.
`include "euler_trs_matrix_compose_unit_assert.svh"

module euler_trs_matrix_compose_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  etmc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output etmc_pkg::rsp_type rsp_payload
);
   import etmc_pkg::*;

   logic [TOTAL_LAT-1:0] vld_ff;
   logic [TOTAL_LAT-1:0] vld_in;
   scale_type            scl_dly_ff [0:LANE_LAT-1];
   elem_type             px_dly_ff  [0:TOTAL_LAT-1];
   elem_type             py_dly_ff  [0:TOTAL_LAT-1];
   elem_type             pz_dly_ff  [0:TOTAL_LAT-1];

   trig_type  trig;
   mat_type   mat;
   logic      adv;
   logic      load;

   mat_type   rows_ff;
   elem_type  px_ff, py_ff, pz_ff;
   logic [1:0] row_ff;
   logic [1:0] row_in;
   logic       busy_ff;
   logic       busy_in;

   etmc_cordic_lane u_lane_x (
      .clock(clock), .en(adv), .angle(req_payload.angle_x),
      .sin_out(trig.sx), .cos_out(trig.cx)
   );
   etmc_cordic_lane u_lane_y (
      .clock(clock), .en(adv), .angle(req_payload.angle_y),
      .sin_out(trig.sy), .cos_out(trig.cy)
   );
   etmc_cordic_lane u_lane_z (
      .clock(clock), .en(adv), .angle(req_payload.angle_z),
      .sin_out(trig.sz), .cos_out(trig.cz)
   );

   etmc_merge u_merge (
      .clock(clock), .en(adv), .trig(trig),
      .scale(scl_dly_ff[LANE_LAT-1]), .mat(mat)
   );

   assign load      = vld_ff[TOTAL_LAT-1] && (!busy_ff || (rsp_ready && row_ff == 2'd3));
   assign adv       = !vld_ff[TOTAL_LAT-1] || load;
   assign req_ready = adv;

   assign vld_in = {vld_ff[TOTAL_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scl_dly_ff[0] <= '{req_payload.scale_x, req_payload.scale_y, req_payload.scale_z};
         px_dly_ff[0]  <= req_payload.pos_x;
         py_dly_ff[0]  <= req_payload.pos_y;
         pz_dly_ff[0]  <= req_payload.pos_z;
         for (int i = 1; i < LANE_LAT; i++) begin
            scl_dly_ff[i] <= scl_dly_ff[i-1];
         end
         for (int i = 1; i < TOTAL_LAT; i++) begin
            px_dly_ff[i] <= px_dly_ff[i-1];
            py_dly_ff[i] <= py_dly_ff[i-1];
            pz_dly_ff[i] <= pz_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      if (load) begin
         busy_in = 1'b1;
         row_in  = 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (row_ff == 2'd3) begin
            busy_in = 1'b0;
         end else begin
            row_in = row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rows_ff <= mat;
         px_ff   <= px_dly_ff[TOTAL_LAT-1];
         py_ff   <= py_dly_ff[TOTAL_LAT-1];
         pz_ff   <= pz_dly_ff[TOTAL_LAT-1];
      end
   end

   assign rsp_valid = busy_ff;

   always_comb begin
      rsp_payload.row_index = row_ff;
      rsp_payload.last_row  = (row_ff == 2'd3);
      unique case (row_ff)
         2'd0, 2'd1, 2'd2: begin
            rsp_payload.elem0 = rows_ff[row_ff][0];
            rsp_payload.elem1 = rows_ff[row_ff][1];
            rsp_payload.elem2 = rows_ff[row_ff][2];
            rsp_payload.elem3 = '0;
         end
         default: begin
            rsp_payload.elem0 = px_ff;
            rsp_payload.elem1 = py_ff;
            rsp_payload.elem2 = pz_ff;
            rsp_payload.elem3 = ONE_Q16;
         end
      endcase
   end

   `ETMC_ASSERT_NEXT(a_load_starts_row0, load, busy_ff && row_ff == 2'd0, "load did not start at row 0")
   `ETMC_ASSERT_NEXT(a_row_steps, busy_ff && rsp_ready && row_ff != 2'd3 && !load, row_ff == $past(row_ff) + 2'd1, "row did not advance")
   `ETMC_ASSERT_NEXT(a_row_holds, busy_ff && !rsp_ready, busy_ff && $stable(row_ff), "row changed while stalled")
   `ETMC_ASSERT_NOW(a_full_blocks_input, vld_ff[TOTAL_LAT-1] && !load, !req_ready, "input taken while pipeline frozen")

endmodule

[tb/etmc_checker.sv]
// Checker for the matrix compose unit: predicts row transactions and compares them
module etmc_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  etmc_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  etmc_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                rows_pending
);
   import etmc_pkg::*;

   localparam int STEPS = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;

   rsp_type row_queue[$];

   function automatic longint atan_step(input int idx);
      longint tbl[24] = '{
         64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
         64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return tbl[idx];
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [31:0] scale_sat(input longint e, input longint s);
      longint v;
      v = (e * s + (64'sd1 <<< 21)) >>> 22;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 262144;
      x = 652032874;
      y = 0;
      flip = 0;
      while (z > 64'sd3373259426) z -= 64'sd6746518852;
      while (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   task automatic predict_rows(input req_type t);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      longint m[3][3];
      longint sc[3];
      rsp_type r;
      sin_cos(t.angle_x, sx, cx);
      sin_cos(t.angle_y, sy, cy);
      sin_cos(t.angle_z, sz, cz);
      sc[0] = t.scale_x; sc[1] = t.scale_y; sc[2] = t.scale_z;
      sxsy = q30_mul(sx, sy);
      cxsy = q30_mul(cx, sy);
      m[0][0] = q30_mul(cy, cz);
      m[0][1] = q30_mul(cy, sz);
      m[0][2] = -sy;
      m[1][0] = -q30_mul(sxsy, cz) - q30_mul(cx, sz);
      m[1][1] = -q30_mul(sxsy, sz) + q30_mul(cx, cz);
      m[1][2] = -q30_mul(sx, cy);
      m[2][0] = q30_mul(cxsy, cz) - q30_mul(sx, sz);
      m[2][1] = q30_mul(cxsy, sz) + q30_mul(sx, cz);
      m[2][2] = q30_mul(cx, cy);
      for (int k = 0; k < 3; k++) begin
         r.row_index = 2'(k);
         r.elem0 = scale_sat(m[k][0], sc[0]);
         r.elem1 = scale_sat(m[k][1], sc[1]);
         r.elem2 = scale_sat(m[k][2], sc[2]);
         r.elem3 = '0;
         r.last_row = 1'b0;
         row_queue.push_back(r);
      end
      r.row_index = 2'd3;
      r.elem0 = t.pos_x;
      r.elem1 = t.pos_y;
      r.elem2 = t.pos_z;
      r.elem3 = ONE_Q16;
      r.last_row = 1'b1;
      row_queue.push_back(r);
   endtask

   task automatic compare_row(input rsp_type got);
      rsp_type want;
      if (row_queue.size() == 0) begin
         $error("unexpected row transaction %p", got);
         fail_count++;
      end else begin
         want = row_queue.pop_front();
         if (got.row_index !== want.row_index) begin
            $error("row_index exp %0d got %0d", want.row_index, got.row_index);
            fail_count++;
         end
         if (got.elem0 !== want.elem0) begin
            $error("elem0 exp %0d got %0d", want.elem0, got.elem0);
            fail_count++;
         end
         if (got.elem1 !== want.elem1) begin
            $error("elem1 exp %0d got %0d", want.elem1, got.elem1);
            fail_count++;
         end
         if (got.elem2 !== want.elem2) begin
            $error("elem2 exp %0d got %0d", want.elem2, got.elem2);
            fail_count++;
         end
         if (got.elem3 !== want.elem3) begin
            $error("elem3 exp %0d got %0d", want.elem3, got.elem3);
            fail_count++;
         end
         if (got.last_row !== want.last_row) begin
            $error("last_row exp %0d got %0d", want.last_row, got.last_row);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count = 0;
      rows_pending = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) compare_row(rsp_payload);
         if (req_valid && req_ready) predict_rows(req_payload);
         rows_pending = row_queue.size();
      end
   end

endmodule

[tb/tb.sv]
// Testbench top for the matrix compose unit: stimulus, stalls and verdict
module tb;
   import etmc_pkg::*;

   localparam int NUM_RANDOM = 110;
   localparam int NUM_HOLD   = 40;
   localparam int IDLE_LIMIT = 4000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;
   int      fail_count;
   int      rows_pending;
   bit      hold_rsp = 0;
   int      idle_cycles = 0;

   always #2 clock = ~clock;

   euler_trs_matrix_compose_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   etmc_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .rows_pending(rows_pending)
   );

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_angle();
      int p;
      p = $urandom_range(0, 9);
      case (p)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(12868 + $urandom_range(0, 2)); // near pi
         3: return 16'(6434 + $urandom_range(0, 2) - 1); // near pi/2
         4: return 16'(-6434 - $urandom_range(0, 2) + 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      int p;
      p = $urandom_range(0, 9);
      case (p)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0100;
         3: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_item();
      req_type t;
      t.pos_x = $urandom;
      t.pos_y = $urandom;
      t.pos_z = $urandom;
      t.angle_x = pick_angle();
      t.angle_y = pick_angle();
      t.angle_z = pick_angle();
      t.scale_x = pick_scale();
      t.scale_y = pick_scale();
      t.scale_z = pick_scale();
      return t;
   endfunction

   // valid stays high after acceptance; the caller drops it when idling
   task automatic send(input req_type t);
      req_payload <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_uniform(input logic [31:0] p, input logic [15:0] a,
                               input logic [15:0] s);
      req_type t;
      t.pos_x = p; t.pos_y = ~p; t.pos_z = p;
      t.angle_x = a; t.angle_y = a; t.angle_z = a;
      t.scale_x = s; t.scale_y = s; t.scale_z = s;
      send(t);
   endtask

   // receiver
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int g;
      req_type t;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, quadrant folds, saturation
      send_uniform(32'h0, 16'h0, 16'h0100);
      send_uniform(32'h7FFFFFFF, 16'h7FFF, 16'h7FFF);
      send_uniform(32'h80000000, 16'h8000, 16'h8000);
      send_uniform(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      send_uniform(32'h00010000, 16'd6434, 16'h0100);
      send_uniform(32'h00010000, -16'sd6434, 16'h0100);
      send_uniform(32'h12345678, 16'd6435, 16'h0200);
      send_uniform(32'h12345678, -16'sd6435, 16'h0200);
      send_uniform(32'hA5A5A5A5, 16'd12867, 16'h0100);
      send_uniform(32'h5A5A5A5A, 16'd12868, 16'h0100);
      send_uniform(32'h5A5A5A5A, -16'sd12868, 16'hFF00);
      send_uniform(32'h0000FFFF, 16'd25736, 16'h7FFF);
      send_uniform(32'hFFFF0000, 16'h5555, 16'hAAAA);
      send_uniform(32'h55555555, 16'hAAAA, 16'h5555);
      t = '0; t.angle_x = 16'd3217; t.angle_y = -16'sd1000; t.angle_z = 16'd20000;
      t.scale_x = 16'h7FFF; t.scale_y = 16'h8000; t.scale_z = 16'h0001;
      send(t);
      req_valid <= 1'b0;

      // pause until drained
      while (rows_pending != 0) @(negedge clock);
      repeat (TOTAL_LAT + 8) @(negedge clock);

      // long receiver hold-off while inputs keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
         begin
            for (int k = 0; k < NUM_HOLD; k++) send(random_item());
            req_valid <= 1'b0;
         end
      join
      @(negedge clock);

      for (int k = 0; k < NUM_RANDOM; k++) begin
         g = (k >= 40 && k < 70) ? 0 : gap_len();
         if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
         send(random_item());
      end
      req_valid <= 1'b0;

      while (rows_pending != 0) @(negedge clock);
      repeat (TOTAL_LAT + 8) @(negedge clock);
      if (fail_count == 0 && rows_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
